// ===== rtl/taab_pkg.sv =====
// Shared types and constants for the transformed box bounds unit.
`default_nettype none

package taab_pkg;

  typedef logic signed [31:0] q16_t;
  typedef logic signed [63:0] prod_t;

  typedef struct packed {
    q16_t row0_col0;
    q16_t row0_col1;
    q16_t row0_col2;
    q16_t row0_col3;
    q16_t row1_col0;
    q16_t row1_col1;
    q16_t row1_col2;
    q16_t row1_col3;
    q16_t row2_col0;
    q16_t row2_col1;
    q16_t row2_col2;
    q16_t row2_col3;
  } taab_in_t;

  typedef struct packed {
    q16_t world_min_x;
    q16_t world_min_y;
    q16_t world_min_z;
    q16_t world_max_x;
    q16_t world_max_y;
    q16_t world_max_z;
  } taab_out_t;

  typedef struct packed {
    q16_t min_x;
    q16_t min_y;
    q16_t min_z;
    q16_t max_x;
    q16_t max_y;
    q16_t max_z;
  } taab_box_t;

  // Products of one matrix row with both extremes of each local axis.
  typedef struct packed {
    prod_t x_lo;
    prod_t x_hi;
    prod_t y_lo;
    prod_t y_hi;
    prod_t z_lo;
    prod_t z_hi;
    q16_t  trans;
  } taab_prod_t;

  typedef enum logic [2:0] {
    REG_BOX_MIN_X = 3'd0,
    REG_BOX_MIN_Y = 3'd1,
    REG_BOX_MIN_Z = 3'd2,
    REG_BOX_MAX_X = 3'd3,
    REG_BOX_MAX_Y = 3'd4,
    REG_BOX_MAX_Z = 3'd5
  } taab_reg_t;

  localparam int LATENCY = 4;

endpackage

`default_nettype wire

// ===== rtl/transformed_aabb_bounds_unit.sv =====
// Top level: box registers, per-row pipelines and the valid chain.
//
//  channel   ports                         direction  transfer
//  command   start, busy, matrix           in         start && !busy
//  result    done, result                  out        done, one cycle, no hold-off
//  config    wr_en, wr_index, wr_data      in         wr_en, index 0..5, others ignored
//
// One transaction may start every cycle; its result strobes after the multiply, min/max, sum and output registers.
// Stages: 18 parallel 32x32 multiplies, term min/max, exact 66-bit sums,
// floor plus translation plus saturation into the output register.
// rst clears the box registers and the valid chain; busy is high only during reset.
// The receiver cannot stall, so the pipeline advances every cycle.
`default_nettype none

module transformed_aabb_bounds_unit
  import taab_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  taab_in_t   matrix,
  output logic       done,
  output taab_out_t  result,
  input  logic       wr_en,
  input  logic [2:0] wr_index,
  input  q16_t       wr_data
);

  taab_box_t          box;
  logic [LATENCY-1:0] vld;
  taab_prod_t         prod [3];
  q16_t               lo [3];
  q16_t               hi [3];

  assign busy = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      box <= '0;
    end else if (wr_en) begin
      case (taab_reg_t'(wr_index))
        REG_BOX_MIN_X: box.min_x <= wr_data;
        REG_BOX_MIN_Y: box.min_y <= wr_data;
        REG_BOX_MIN_Z: box.min_z <= wr_data;
        REG_BOX_MAX_X: box.max_x <= wr_data;
        REG_BOX_MAX_Y: box.max_y <= wr_data;
        REG_BOX_MAX_Z: box.max_z <= wr_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LATENCY-2:0], start && !busy};
    end
  end

  taab_row_mul u_mul0 (
    .clk(clk), .c0(matrix.row0_col0), .c1(matrix.row0_col1),
    .c2(matrix.row0_col2), .c3(matrix.row0_col3), .box(box), .prod(prod[0])
  );
  taab_row_mul u_mul1 (
    .clk(clk), .c0(matrix.row1_col0), .c1(matrix.row1_col1),
    .c2(matrix.row1_col2), .c3(matrix.row1_col3), .box(box), .prod(prod[1])
  );
  taab_row_mul u_mul2 (
    .clk(clk), .c0(matrix.row2_col0), .c1(matrix.row2_col1),
    .c2(matrix.row2_col2), .c3(matrix.row2_col3), .box(box), .prod(prod[2])
  );

  taab_row_bound u_bnd0 (.clk(clk), .prod(prod[0]), .lo(lo[0]), .hi(hi[0]));
  taab_row_bound u_bnd1 (.clk(clk), .prod(prod[1]), .lo(lo[1]), .hi(hi[1]));
  taab_row_bound u_bnd2 (.clk(clk), .prod(prod[2]), .lo(lo[2]), .hi(hi[2]));

  assign done               = vld[LATENCY-1];
  assign result.world_min_x = lo[0];
  assign result.world_min_y = lo[1];
  assign result.world_min_z = lo[2];
  assign result.world_max_x = hi[0];
  assign result.world_max_y = hi[1];
  assign result.world_max_z = hi[2];

`ifndef SYNTHESIS
  a_done_follows_accept: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result strobe without a matching accepted transaction");

  a_no_done_after_reset: assert property (@(posedge clk)
    $fell(rst) |-> !done)
    else $error("result strobe right after reset");

  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.world_min_x <= result.world_max_x) &&
             (result.world_min_y <= result.world_max_y) &&
             (result.world_min_z <= result.world_max_z))
    else $error("result minimum exceeds maximum");
`endif

endmodule

`default_nettype wire

// ===== rtl/taab_row_mul.sv =====
// Multiply stage: one matrix row times both bounds of each local axis.
`default_nettype none

module taab_row_mul
  import taab_pkg::*;
(
  input  logic       clk,
  input  q16_t       c0,
  input  q16_t       c1,
  input  q16_t       c2,
  input  q16_t       c3,
  input  taab_box_t  box,
  output taab_prod_t prod
);

  always_ff @(posedge clk) begin
    prod.x_lo  <= c0 * box.min_x;
    prod.x_hi  <= c0 * box.max_x;
    prod.y_lo  <= c1 * box.min_y;
    prod.y_hi  <= c1 * box.max_y;
    prod.z_lo  <= c2 * box.min_z;
    prod.z_hi  <= c2 * box.max_z;
    prod.trans <= c3;
  end

endmodule

`default_nettype wire

// ===== rtl/taab_row_bound.sv =====
// Per-row bound: pick term extremes, sum exactly, floor to Q16.16, add translation, saturate.
`default_nettype none

module taab_row_bound
  import taab_pkg::*;
(
  input  logic       clk,
  input  taab_prod_t prod,
  output q16_t       lo,
  output q16_t       hi
);

  typedef logic signed [65:0] sum_t;
  typedef logic signed [50:0] wide_t;

  // Corners span every combination of axis bounds, so the extreme sum is the
  // sum of per-term extremes; floor and saturation are monotonic after that.
  prod_t tmin [3];
  prod_t tmax [3];
  q16_t  trans_b;
  sum_t  smin;
  sum_t  smax;
  q16_t  trans_c;
  wide_t wmin;
  wide_t wmax;

  function automatic q16_t sat(input wide_t v);
    q16_t r;
    if (v[50:31] == {20{v[50]}}) begin
      r = v[31:0];
    end else if (v[50]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7fff_ffff;
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    tmin[0] <= (prod.x_lo < prod.x_hi) ? prod.x_lo : prod.x_hi;
    tmax[0] <= (prod.x_lo < prod.x_hi) ? prod.x_hi : prod.x_lo;
    tmin[1] <= (prod.y_lo < prod.y_hi) ? prod.y_lo : prod.y_hi;
    tmax[1] <= (prod.y_lo < prod.y_hi) ? prod.y_hi : prod.y_lo;
    tmin[2] <= (prod.z_lo < prod.z_hi) ? prod.z_lo : prod.z_hi;
    tmax[2] <= (prod.z_lo < prod.z_hi) ? prod.z_hi : prod.z_lo;
    trans_b <= prod.trans;
  end

  always_ff @(posedge clk) begin
    smin    <= sum_t'(tmin[0]) + sum_t'(tmin[1]) + sum_t'(tmin[2]);
    smax    <= sum_t'(tmax[0]) + sum_t'(tmax[1]) + sum_t'(tmax[2]);
    trans_c <= trans_b;
  end

  // arithmetic drop of the low 16 bits is a floor
  assign wmin = wide_t'($signed(smin[65:16])) + wide_t'(trans_c);
  assign wmax = wide_t'($signed(smax[65:16])) + wide_t'(trans_c);

  always_ff @(posedge clk) begin
    lo <= sat(wmin);
    hi <= sat(wmax);
  end

endmodule

`default_nettype wire

// ===== sim/transformed_aabb_bounds_checker.sv =====
// Checker: follows the box registers, predicts transformed bounds and compares each result.
module transformed_aabb_bounds_checker
  import taab_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       busy,
  input  taab_in_t   matrix,
  input  logic       done,
  input  taab_out_t  result,
  input  logic       wr_en,
  input  logic [2:0] wr_index,
  input  q16_t       wr_data,
  output int         fail_count,
  output int         pending,
  output int         checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic signed [67:0] SUM_MAX = 68'sd2147483647;
  localparam logic signed [67:0] SUM_MIN = -68'sd2147483648;

  taab_box_t box_regs;
  taab_out_t bounds_q [$];
  taab_out_t want;
  int        reported;
  string     field_names [6] = '{"world_min_x", "world_min_y", "world_min_z",
                                 "world_max_x", "world_max_y", "world_max_z"};

  // Eight corners through rows 0..2 with w = 1; exact sum, floor to Q16.16, saturate.
  function automatic taab_out_t transform_bounds(taab_in_t m, taab_box_t b);
    q16_t               rows [3][4];
    q16_t               lo_v [3];
    q16_t               hi_v [3];
    q16_t               px, py, pz, v;
    logic signed [63:0] p0, p1, p2;
    logic signed [67:0] acc, tr;
    rows = '{'{m.row0_col0, m.row0_col1, m.row0_col2, m.row0_col3},
             '{m.row1_col0, m.row1_col1, m.row1_col2, m.row1_col3},
             '{m.row2_col0, m.row2_col1, m.row2_col2, m.row2_col3}};
    for (int c = 0; c < 8; c++) begin
      px = c[2] ? b.max_x : b.min_x;
      py = c[1] ? b.max_y : b.min_y;
      pz = c[0] ? b.max_z : b.min_z;
      for (int k = 0; k < 3; k++) begin
        p0 = rows[k][0] * px;
        p1 = rows[k][1] * py;
        p2 = rows[k][2] * pz;
        tr = rows[k][3];
        tr = tr <<< 16;
        acc = p0 + p1 + p2 + tr;
        acc = acc >>> 16;
        if (acc > SUM_MAX) begin
          v = 32'sh7fff_ffff;
        end else if (acc < SUM_MIN) begin
          v = 32'sh8000_0000;
        end else begin
          v = acc[31:0];
        end
        if (c == 0 || v < lo_v[k]) lo_v[k] = v;
        if (c == 0 || v > hi_v[k]) hi_v[k] = v;
      end
    end
    return {lo_v[0], lo_v[1], lo_v[2], hi_v[0], hi_v[1], hi_v[2]};
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      box_regs <= '0;
      bounds_q.delete();
      pending <= 0;
    end else begin
      // pop before push: a result is always older than a transaction taken this cycle
      if (done) begin
        if (bounds_q.size() == 0) begin
          fail_count++;
          reported++;
          if (reported <= 10) $display("unexpected result %h with nothing outstanding", result);
        end else begin
          want = bounds_q.pop_front();
          checked++;
          for (int f = 0; f < 6; f++) begin
            if (result[191-32*f -: 32] !== want[191-32*f -: 32]) begin
              fail_count++;
              reported++;
              if (reported <= 10)
                $display("mismatch on %s (result %0d): expected %h, got %h",
                         field_names[f], checked, want[191-32*f -: 32],
                         result[191-32*f -: 32]);
            end
          end
        end
      end
      if (start && !busy)
        bounds_q.insert(bounds_q.size(), transform_bounds(matrix, box_regs));
      if (wr_en) begin
        case (wr_index)
          REG_BOX_MIN_X: box_regs.min_x <= wr_data;
          REG_BOX_MIN_Y: box_regs.min_y <= wr_data;
          REG_BOX_MIN_Z: box_regs.min_z <= wr_data;
          REG_BOX_MAX_X: box_regs.max_x <= wr_data;
          REG_BOX_MAX_Y: box_regs.max_y <= wr_data;
          REG_BOX_MAX_Z: box_regs.max_z <= wr_data;
          default: ;
        endcase
      end
      pending <= bounds_q.size();
    end
  end

endmodule

// ===== sim/transformed_aabb_bounds_unit_test.sv =====
// Top of the bench: clock, reset, matrix and box register stimulus, watchdog and verdict.
module transformed_aabb_bounds_unit_test
  import taab_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         WATCHDOG_LIMIT  = 2000;
  localparam int         RANDOM_PHASES   = 8;
  localparam int         ITEMS_PER_PHASE = 48;
  // indexes past the box registers; writes there must be dropped
  localparam logic [2:0] REG_SPARE_6     = 3'd6;
  localparam logic [2:0] REG_SPARE_7     = 3'd7;
  localparam q16_t       Q_ONE           = 32'sh0001_0000;
  localparam q16_t       Q_MAX           = 32'sh7fff_ffff;
  localparam q16_t       Q_MIN           = 32'sh8000_0000;

  typedef enum int {VAL_SMALL, VAL_FULL, VAL_EDGE} val_kind_e;
  typedef enum int {BOX_ORDERED, BOX_FULL, BOX_EDGE, BOX_INVERTED} box_kind_e;

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  taab_in_t   matrix;
  logic       done;
  taab_out_t  result;
  logic       wr_en;
  logic [2:0] wr_index;
  q16_t       wr_data;

  int fail_count;
  int pending;
  int checked;
  int items_sent;
  int box_settings;
  int quiet_cycles;

  transformed_aabb_bounds_unit dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .matrix   (matrix),
    .done     (done),
    .result   (result),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  transformed_aabb_bounds_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .matrix     (matrix),
    .done       (done),
    .result     (result),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || wr_en) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
               quiet_cycles, pending);
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic q16_t pick_q16(val_kind_e kind);
    q16_t edges [8];
    edges = '{Q_MIN, Q_MAX, 32'sd0, -32'sd1, 32'sd1, Q_ONE, -Q_ONE, 32'sh4000_0000};
    case (kind)
      VAL_SMALL: return q16_t'($urandom_range(0, 32'h8_0000)) - 32'sh4_0000;  // +-4.0
      VAL_FULL:  return q16_t'($urandom);
      default:   return edges[$urandom_range(0, 7)];
    endcase
  endfunction

  // diagonal d, off-diagonal o, translation t
  function automatic taab_in_t affine(q16_t d, q16_t o, q16_t t);
    return '{d, o, o, t, o, d, o, t, o, o, d, t};
  endfunction

  function automatic taab_in_t random_matrix();
    taab_in_t  m;
    int        mode;
    val_kind_e kind;
    mode = $urandom_range(0, 19);
    for (int i = 0; i < 12; i++) begin
      if (mode < 14) kind = VAL_SMALL;
      else if (mode < 17) kind = VAL_FULL;
      else kind = val_kind_e'($urandom_range(0, 2));
      m[383-32*i -: 32] = pick_q16(kind);
    end
    return m;
  endfunction

  function automatic taab_box_t make_box(box_kind_e kind);
    q16_t      a [3];
    q16_t      c [3];
    q16_t      tmp;
    val_kind_e vk;
    vk = (kind == BOX_FULL) ? VAL_FULL : (kind == BOX_EDGE) ? VAL_EDGE : VAL_SMALL;
    for (int i = 0; i < 3; i++) begin
      a[i] = pick_q16(vk);
      c[i] = pick_q16(vk);
      if ((kind == BOX_ORDERED && a[i] > c[i]) || (kind == BOX_INVERTED && a[i] < c[i])) begin
        tmp = a[i];
        a[i] = c[i];
        c[i] = tmp;
      end
    end
    return {a[0], a[1], a[2], c[0], c[1], c[2]};
  endfunction

  // 0: back to back, 1: full random gaps, 2: mostly back to back
  function automatic int draw_gap(int mode);
    case (mode)
      0:       return 0;
      1:       return $urandom_range(0, 15);
      default: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0;
    endcase
  endfunction

  task automatic send_matrix(input taab_in_t m, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start  <= 1'b1;
    matrix <= m;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // spare indexes are written around the real ones with junk data
  task automatic program_box(input taab_box_t b);
    logic [2:0] idx [8];
    q16_t       val [8];
    idx = '{REG_SPARE_6, REG_BOX_MIN_X, REG_BOX_MIN_Y, REG_BOX_MIN_Z,
            REG_BOX_MAX_X, REG_BOX_MAX_Y, REG_BOX_MAX_Z, REG_SPARE_7};
    val = '{q16_t'($urandom), b.min_x, b.min_y, b.min_z,
            b.max_x, b.max_y, b.max_z, q16_t'($urandom)};
    for (int i = 0; i < 8; i++) begin
      wr_en    <= 1'b1;
      wr_index <= idx[i];
      wr_data  <= val[i];
      @(posedge clk);
    end
    wr_en <= 1'b0;
    box_settings++;
  endtask

  initial begin
    int gap_mode;
    rst      <= 1'b1;
    start    <= 1'b0;
    matrix   <= '0;
    wr_en    <= 1'b0;
    wr_index <= '0;
    wr_data  <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // box still at reset: every corner is the origin, so only translation shows
    send_matrix(affine(Q_ONE, 32'sd0, 32'sd0), draw_gap(1));
    send_matrix(affine(Q_MAX, Q_MIN, Q_MAX), draw_gap(1));
    send_matrix(affine(Q_MIN, Q_MAX, Q_MIN), 0);
    send_matrix(random_matrix(), draw_gap(1));

    // unit cube: identity, negation, saturation both ways, floor of tiny negatives
    wait_drained();
    program_box('{-Q_ONE, -Q_ONE, -Q_ONE, Q_ONE, Q_ONE, Q_ONE});
    send_matrix(affine(Q_ONE, 32'sd0, 32'sd0), 0);
    send_matrix(affine(-Q_ONE, 32'sd0, Q_ONE), 0);
    send_matrix(affine(Q_MAX, Q_MAX, Q_MAX), draw_gap(1));
    send_matrix(affine(Q_MIN, Q_MIN, Q_MIN), 0);
    send_matrix(affine(-32'sd1, 32'sd0, 32'sd0), draw_gap(1));
    send_matrix(affine(32'sd1, 32'sd1, -32'sd1), 0);
    send_matrix(affine(32'sd0, 32'sd0, 32'sd0), draw_gap(1));
    send_matrix(affine(Q_ONE, Q_ONE, Q_MIN), 0);

    // widest possible box
    wait_drained();
    program_box('{Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX});
    send_matrix(affine(Q_MAX, Q_MIN, 32'sd0), 0);
    send_matrix(affine(Q_MIN, Q_MIN, Q_MAX), draw_gap(1));
    send_matrix(affine(32'sd1, 32'sd1, 32'sd0), 0);
    send_matrix(affine(Q_ONE, 32'sd0, 32'sd0), 0);
    send_matrix(affine(-Q_ONE, -32'sd1, Q_MAX), draw_gap(1));

    // minimum above maximum on every axis
    wait_drained();
    program_box('{32'sh2_0000, 32'sh1_8000, 32'sh0_4000,
                  -32'sh3_0000, -32'sh0_8000, -32'sh0_c000});
    send_matrix(affine(Q_ONE, 32'sd0, 32'sd0), 0);
    send_matrix(affine(-Q_ONE, 32'sh0_8000, Q_ONE), draw_gap(1));
    send_matrix(random_matrix(), 0);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_drained();
      program_box(make_box(box_kind_e'(ph % 4)));
      gap_mode = ph % 3;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(0, 31) == 0) wait_drained();
        send_matrix(random_matrix(), draw_gap(gap_mode));
      end
    end

    wait_drained();
    repeat (LATENCY + 2) @(posedge clk);
    $display("Sent %0d matrices and checked %0d bounds over %0d box settings,",
             items_sent, checked, box_settings);
    $display("covering saturation, inverted boxes and writes to unused register slots.");
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
